// ----- rtl/core/vpa_pkg.sv -----
// vpa_pkg: shared types and codes for the variable partition allocator
// no dependencies
package vpa_pkg;

   typedef enum logic [2:0] {
      OP_ALLOC    = 3'd0,
      OP_FREE     = 3'd1,
      OP_SWAP     = 3'd2,
      OP_FREE_PID = 3'd3,
      OP_COMPACT  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_ZERO       = 3'd1,
      ST_NO_SPACE   = 3'd2,
      ST_NOT_FOUND  = 3'd3,
      ST_NO_SWAP    = 3'd4,
      ST_FULL       = 3'd5,
      ST_NO_COMPACT = 3'd6
   } status_type;

   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   // one table row: start, size, owner, free, swapped
   typedef struct packed {
      logic [15:0] start;
      logic [15:0] size;
      logic [15:0] owner;
      logic        free;
      logic        swapped;
   } seg_type;

endpackage

// ----- rtl/core/variable_partition_allocator.sv -----
// variable_partition_allocator: segment table allocator, top level
// depends on vpa_pkg
//
// usage
//  - configuration: csr_we / csr_wdata write fit_mode (0 first, 1 best,
//    2 worst fit, 3 first fit); write only while busy is low
//  - request channel: a request is taken at a clock edge with start high
//    and busy low; fields req_operation, req_request_size, req_process_id,
//    req_release_address
//  - response channel: each response is on the rsp_ ports for exactly one
//    cycle with rsp_valid high; rsp_last_result marks the last one.
//    the receiver cannot stall, so no response is ever held back
//  - the segment table lives in a memory with one write port and one read
//    port and a registered read; every operation but a zero-size alloc or an
//    unknown code walks the table through it, one entry at a time
//  - an alloc with an exact fit takes over the entry; otherwise the front is
//    split off and the upper entries are shifted up by one. compact raises
//    one response per resident segment. rsp_valid and the rsp_ fields are
//    registered outputs
//  - a new request is taken only after the block has passed S_DONE back to
//    S_IDLE (busy low); unknown operation codes finish with no response
//  - reset: busy stays high for one cycle after reset while entry 0 is
//    written with one free segment covering all memory
module variable_partition_allocator
   import vpa_pkg::*;
#(
   parameter int MAX_SEGMENTS = 32,
   parameter int TOTAL_KB     = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_operation,
   input  logic [15:0] req_request_size,
   input  logic [15:0] req_process_id,
   input  logic [15:0] req_release_address,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_result_address,
   output logic [15:0] rsp_former_address,
   output logic [15:0] rsp_result_size,
   output logic [15:0] rsp_result_owner,
   output logic [6:0]  rsp_segment_count,
   output logic        rsp_last_result
);

   localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_SEGMENTS);
   localparam logic [15:0] TOTAL = 16'(TOTAL_KB);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      // generic merge pass: reads i, then i+1, writes, compaction style
      S_M_RD, S_M_RD2, S_M_CHK,
      S_F_RD, S_F_CHK,            // alloc fit search
      S_A_RD, S_A_HIT,            // alloc apply
      S_SH_RD, S_SH_WR,           // shift up for insert
      S_FA_RD, S_FA_CHK,          // free by address search
      S_SW_RD, S_SW_CHK,          // swap out
      S_FP_RD,                    // free by process
      S_C_RD, S_C_CHK, S_C_TAIL,  // compact
      S_DONE
   } state_type;

   // merge modes
   typedef enum logic [1:0] {
      MG_AVAIL, MG_FREE, MG_FREE_PID
   } merge_type;

   // ---- segment memory: one write port, one read port, registered read
   seg_type          mem [MAX_SEGMENTS];
   logic             mem_we;
   logic [IW-1:0]    mem_waddr;
   seg_type          mem_wdata;
   logic [IW-1:0]    mem_raddr;
   seg_type          mem_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   // ---- control registers
   state_type     state_ff, state_in;
   merge_type     mode_ff, mode_in;
   logic [1:0]    fit_ff;
   logic [CW-1:0] total_ff, total_in;   // live segment count
   logic [CW-1:0] i_ff, i_in;           // read cursor
   logic [CW-1:0] w_ff, w_in;           // write cursor (merge / compact)
   seg_type       acc_ff, acc_in;       // segment being merged or moved
   logic          has_ff, has_in;       // acc holds a segment
   logic [2:0]    op_ff, op_in;
   logic [15:0]   req_ff, req_in;
   logic [15:0]   pid_ff, pid_in;
   logic [15:0]   addr_ff, addr_in;
   logic          best_ok_ff, best_ok_in;
   logic [CW-1:0] best_ff, best_in;
   logic [15:0]   bsize_ff, bsize_in;
   logic [15:0]   sum_ff, sum_in;       // KB total / compaction cursor
   logic [6:0]    cnt_ff, cnt_in;
   seg_type       hold_ff, hold_in;     // held packed segment for compact
   logic          hold_v_ff, hold_v_in;
   logic          rv_in;
   logic [2:0]    rst_in;
   logic [15:0]   ra_in, fa_in, rs_in, ro_in;
   logic [6:0]    rc_in;
   logic          rl_in;

   assign busy = (state_ff != S_IDLE);

   seg_type rd;
   assign rd = mem_rdata_ff;

   logic rd_avail;
   assign rd_avail = rd.free | rd.swapped;

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      total_in   = total_ff;
      i_in       = i_ff;
      w_in       = w_ff;
      acc_in     = acc_ff;
      has_in     = has_ff;
      op_in      = op_ff;
      req_in     = req_ff;
      pid_in     = pid_ff;
      addr_in    = addr_ff;
      best_ok_in = best_ok_ff;
      best_in    = best_ff;
      bsize_in   = bsize_ff;
      sum_in     = sum_ff;
      cnt_in     = cnt_ff;
      hold_in    = hold_ff;
      hold_v_in  = hold_v_ff;
      mem_we     = 1'b0;
      mem_waddr  = i_ff[IW-1:0];
      mem_wdata  = acc_ff;
      mem_raddr  = i_ff[IW-1:0];
      rv_in      = 1'b0;
      rst_in     = ST_OK;
      ra_in      = '0;
      fa_in      = '0;
      rs_in      = '0;
      ro_in      = '0;
      rc_in      = '0;
      rl_in      = 1'b1;

      case (state_ff)
         S_CLEAR: begin
            // write the whole-memory free segment at entry 0
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{start: '0, size: TOTAL, owner: '0, free: 1'b1,
                          swapped: 1'b0};
            total_in  = CW'(1);
            state_in  = S_IDLE;
         end

         S_IDLE: begin
            i_in = '0;
            w_in = '0;
            has_in = 1'b0;
            if (start) begin
               op_in   = req_operation;
               req_in  = req_request_size;
               pid_in  = req_process_id;
               addr_in = req_release_address;
               sum_in  = '0;
               cnt_in  = '0;
               best_ok_in = 1'b0;
               hold_v_in  = 1'b0;
               case (req_operation)
                  OP_ALLOC: begin
                     if (req_request_size == '0) begin
                        rv_in    = 1'b1;
                        rst_in   = ST_ZERO;
                        state_in = S_DONE;
                     end else begin
                        mode_in  = MG_AVAIL;
                        state_in = S_M_RD;
                     end
                  end
                  OP_FREE:     state_in = S_FA_RD;
                  OP_SWAP:     state_in = S_SW_RD;
                  OP_FREE_PID: state_in = S_FP_RD;
                  OP_COMPACT:  state_in = S_C_RD;
                  default:     state_in = S_DONE;
               endcase
            end
         end

         // ---- streaming merge: read each entry, fold into acc, write out
         // at the write cursor. MG_FREE_PID also frees pid-owned entries
         S_M_RD: begin
            if (i_ff == total_ff) begin
               if (has_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = w_ff[IW-1:0];
                  mem_wdata = acc_ff;
                  w_in      = w_ff + CW'(1);
               end
               state_in = S_M_CHK;
            end else begin
               state_in = S_M_RD2;
            end
         end

         S_M_RD2: begin
            // rd holds entry i
            seg_type s;
            logic    joinable;
            s = rd;
            if (mode_ff == MG_FREE_PID && !s.free && s.owner == pid_ff) begin
               sum_in = sum_ff + s.size;
               cnt_in = cnt_ff + 7'd1;
               s.free = 1'b1;
               s.swapped = 1'b0;
               s.owner = '0;
            end
            if (mode_ff == MG_AVAIL) begin
               joinable = has_ff && (acc_ff.free | acc_ff.swapped) &&
                          (s.free | s.swapped);
            end else begin
               joinable = has_ff && acc_ff.free && s.free;
            end
            if (joinable) begin
               acc_in.size = acc_ff.size + s.size;
               if (mode_ff == MG_AVAIL) begin
                  acc_in.free = 1'b1;
                  acc_in.swapped = 1'b0;
                  acc_in.owner = '0;
               end
            end else begin
               if (has_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = w_ff[IW-1:0];
                  mem_wdata = acc_ff;
                  w_in      = w_ff + CW'(1);
               end
               acc_in = s;
            end
            has_in   = 1'b1;
            i_in     = i_ff + CW'(1);
            mem_raddr = i_in[IW-1:0];
            state_in = S_M_RD;
         end

         S_M_CHK: begin
            total_in = w_ff;
            i_in     = '0;
            has_in   = 1'b0;
            case (op_ff)
               OP_ALLOC: state_in = S_F_RD;
               OP_FREE: begin
                  rv_in    = 1'b1;
                  ra_in    = addr_ff;
                  rs_in    = hold_ff.size;
                  ro_in    = hold_ff.owner;
                  state_in = S_DONE;
               end
               default: begin
                  rv_in = 1'b1;
                  if (cnt_ff == '0) begin
                     rst_in = ST_NOT_FOUND;
                  end else begin
                     rs_in = sum_ff;
                     ro_in = pid_ff;
                     rc_in = cnt_ff;
                  end
                  state_in = S_DONE;
               end
            endcase
         end

         // ---- fit search over the merged table
         S_F_RD: begin
            if (i_ff == total_ff) begin
               state_in = S_A_RD;
            end else begin
               state_in = S_F_CHK;
            end
         end

         S_F_CHK: begin
            logic take;
            take = 1'b0;
            if (rd_avail && rd.size >= req_ff) begin
               if (fit_ff == FIT_BEST) begin
                  take = !best_ok_ff || rd.size < bsize_ff;
               end else if (fit_ff == FIT_WORST) begin
                  take = !best_ok_ff || rd.size > bsize_ff;
               end else begin
                  take = !best_ok_ff;
               end
            end
            if (take) begin
               best_ok_in = 1'b1;
               best_in    = i_ff;
               bsize_in   = rd.size;
            end
            i_in      = i_ff + CW'(1);
            mem_raddr = i_in[IW-1:0];
            state_in  = S_F_RD;
         end

         S_A_RD: begin
            mem_raddr = best_ff[IW-1:0];
            if (!best_ok_ff) begin
               rv_in    = 1'b1;
               rst_in   = ST_NO_SPACE;
               state_in = S_DONE;
            end else if (bsize_ff != req_ff && total_ff >= MAX_C) begin
               rv_in    = 1'b1;
               rst_in   = ST_FULL;
               state_in = S_DONE;
            end else begin
               state_in = S_A_HIT;
            end
         end

         S_A_HIT: begin
            seg_type s;
            s = rd;
            rv_in = 1'b1;
            ra_in = s.start;
            if (s.size == req_ff) begin
               s.free = 1'b0;
               s.swapped = 1'b0;
               s.owner = pid_ff;
               mem_we    = 1'b1;
               mem_waddr = best_ff[IW-1:0];
               mem_wdata = s;
               state_in  = S_DONE;
            end else begin
               // remainder moves up, new owned piece goes at best
               hold_in = '{start: s.start + req_ff, size: s.size - req_ff,
                           owner: s.owner, free: s.free, swapped: s.swapped};
               acc_in  = '{start: s.start, size: req_ff, owner: pid_ff,
                           free: 1'b0, swapped: 1'b0};
               rv_in   = 1'b0;
               addr_in = s.start;
               i_in    = total_ff;
               state_in = S_SH_RD;
            end
         end

         // shift entries best+1..total-1 up by one, top down
         S_SH_RD: begin
            if (i_ff == best_ff + CW'(1)) begin
               mem_we    = 1'b1;
               mem_waddr = i_ff[IW-1:0];
               mem_wdata = hold_ff;
               state_in  = S_SH_WR;
            end else begin
               mem_raddr = IW'(i_ff - CW'(1));
               state_in  = S_SH_WR;
               has_in    = 1'b1;
            end
         end

         S_SH_WR: begin
            if (has_ff) begin
               mem_we    = 1'b1;
               mem_waddr = i_ff[IW-1:0];
               mem_wdata = rd;
               has_in    = 1'b0;
               i_in      = i_ff - CW'(1);
               state_in  = S_SH_RD;
            end else begin
               mem_we    = 1'b1;
               mem_waddr = best_ff[IW-1:0];
               mem_wdata = acc_ff;
               total_in  = total_ff + CW'(1);
               rv_in     = 1'b1;
               ra_in     = addr_ff;
               state_in  = S_DONE;
            end
         end

         // ---- free by address: find first non-free at addr
         S_FA_RD: begin
            if (i_ff == total_ff) begin
               rv_in    = 1'b1;
               rst_in   = ST_NOT_FOUND;
               state_in = S_DONE;
            end else begin
               state_in = S_FA_CHK;
            end
         end

         S_FA_CHK: begin
            if (rd.start == addr_ff && !rd.free) begin
               hold_in   = rd;
               mem_we    = 1'b1;
               mem_waddr = i_ff[IW-1:0];
               mem_wdata = '{start: rd.start, size: rd.size, owner: '0,
                             free: 1'b1, swapped: 1'b0};
               mode_in   = MG_FREE;
               i_in      = '0;
               w_in      = '0;
               has_in    = 1'b0;
               mem_raddr = '0;
               state_in  = S_M_RD;
            end else begin
               i_in      = i_ff + CW'(1);
               mem_raddr = i_in[IW-1:0];
               state_in  = S_FA_RD;
            end
         end

         // ---- swap out
         S_SW_RD: begin
            if (i_ff == total_ff) begin
               rv_in = 1'b1;
               if (cnt_ff == '0) begin
                  rst_in = ST_NO_SWAP;
               end else begin
                  rs_in = sum_ff;
                  ro_in = pid_ff;
                  rc_in = cnt_ff;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_SW_CHK;
            end
         end

         S_SW_CHK: begin
            if (!rd.free && !rd.swapped && rd.owner == pid_ff) begin
               mem_we    = 1'b1;
               mem_waddr = i_ff[IW-1:0];
               mem_wdata = '{start: rd.start, size: rd.size, owner: rd.owner,
                             free: 1'b0, swapped: 1'b1};
               sum_in    = sum_ff + rd.size;
               cnt_in    = cnt_ff + 7'd1;
            end
            i_in      = i_ff + CW'(1);
            mem_raddr = i_in[IW-1:0];
            state_in  = S_SW_RD;
         end

         // ---- free by process: one merging pass that frees as it goes
         S_FP_RD: begin
            mode_in  = MG_FREE_PID;
            state_in = S_M_RD;
         end

         // ---- compact: pack resident entries, one response each
         S_C_RD: begin
            if (i_ff == total_ff) begin
               state_in = S_C_TAIL;
            end else begin
               state_in = S_C_CHK;
            end
         end

         S_C_CHK: begin
            if (!rd.free && !rd.swapped) begin
               if (hold_v_ff) begin
                  // emit the held one now that we know it is not last
                  rv_in     = 1'b1;
                  ra_in     = sum_ff;
                  fa_in     = hold_ff.start;
                  ro_in     = hold_ff.owner;
                  rl_in     = 1'b0;
                  mem_we    = 1'b1;
                  mem_waddr = w_ff[IW-1:0];
                  mem_wdata = '{start: sum_ff, size: hold_ff.size,
                                owner: hold_ff.owner, free: 1'b0,
                                swapped: 1'b0};
                  w_in      = w_ff + CW'(1);
                  sum_in    = sum_ff + hold_ff.size;
               end
               hold_in   = rd;
               hold_v_in = 1'b1;
            end
            i_in      = i_ff + CW'(1);
            mem_raddr = i_in[IW-1:0];
            state_in  = S_C_RD;
         end

         S_C_TAIL: begin
            rv_in = 1'b1;
            if (!hold_v_ff) begin
               rst_in    = ST_NO_COMPACT;
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = '{start: '0, size: TOTAL, owner: '0, free: 1'b1,
                             swapped: 1'b0};
               total_in  = CW'(1);
               state_in  = S_DONE;
            end else begin
               ra_in     = sum_ff;
               fa_in     = hold_ff.start;
               ro_in     = hold_ff.owner;
               mem_we    = 1'b1;
               mem_waddr = w_ff[IW-1:0];
               mem_wdata = '{start: sum_ff, size: hold_ff.size,
                             owner: hold_ff.owner, free: 1'b0, swapped: 1'b0};
               w_in      = w_ff + CW'(1);
               sum_in    = sum_ff + hold_ff.size;
               total_in  = w_ff + CW'(1);
               hold_v_in = 1'b0;
               state_in  = S_DONE;
               if ((32'(sum_ff) + 32'(hold_ff.size)) < 32'(TOTAL_KB) &&
                   (w_ff + CW'(1)) < MAX_C) begin
                  // free tail appended next cycle
                  state_in = S_C_RD;
                  i_in     = total_ff;
                  has_in   = 1'b1;
               end
            end
         end

         S_DONE: state_in = S_IDLE;

         default: state_in = S_IDLE;
      endcase

      // free tail after compaction: reached from S_C_TAIL with has set
      if (state_ff == S_C_RD && has_ff && op_ff == OP_COMPACT) begin
         mem_we    = 1'b1;
         mem_waddr = w_ff[IW-1:0];
         mem_wdata = '{start: sum_ff, size: TOTAL - sum_ff, owner: '0,
                       free: 1'b1, swapped: 1'b0};
         total_in  = w_ff + CW'(1);
         has_in    = 1'b0;
         rv_in     = 1'b0;
         state_in  = S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         fit_ff     <= '0;
         total_ff   <= CW'(1);
         rsp_valid  <= 1'b0;
         mode_ff    <= MG_AVAIL;
         has_ff     <= 1'b0;
         hold_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mode_ff    <= mode_in;
         total_ff   <= total_in;
         has_ff     <= has_in;
         hold_v_ff  <= hold_v_in;
         rsp_valid  <= rv_in;
         if (csr_we) begin
            fit_ff <= csr_wdata;
         end
      end
      i_ff       <= i_in;
      w_ff       <= w_in;
      acc_ff     <= acc_in;
      op_ff      <= op_in;
      req_ff     <= req_in;
      pid_ff     <= pid_in;
      addr_ff    <= addr_in;
      best_ok_ff <= best_ok_in;
      best_ff    <= best_in;
      bsize_ff   <= bsize_in;
      sum_ff     <= sum_in;
      cnt_ff     <= cnt_in;
      hold_ff    <= hold_in;
      rsp_status         <= rst_in;
      rsp_result_address <= ra_in;
      rsp_former_address <= fa_in;
      rsp_result_size    <= rs_in;
      rsp_result_owner   <= ro_in;
      rsp_segment_count  <= rc_in;
      rsp_last_result    <= rl_in;
   end

   // table never grows past its capacity nor empties
   a_total_range: assert property (@(posedge clock) disable iff (reset)
      total_ff <= MAX_C && total_ff != '0)
      else $error("segment count out of range");

   // a request taken while idle makes the block busy
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request taken without going busy");

   // responses only follow a taken request or an operation in flight
   a_rsp_in_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("response outside an operation");

endmodule

// ----- verif/tb.sv -----
// tb: self-checking testbench for the variable partition allocator
// predicts every response from its own copy of the segment table
// depends on vpa_pkg and variable_partition_allocator
`timescale 1ns / 1ps

module tb;
   import vpa_pkg::*;

   localparam int SEG_MAX      = 32;
   localparam int MEM_KB       = 1024;
   localparam int CYCLE_LIMIT  = 600000;
   // an ignored request may still keep the block working after the last response
   localparam int SETTLE_CYCLES = 300;
   localparam logic [1:0] FIT_FIRST     = 2'd0;
   localparam logic [1:0] FIT_FIRST_ALT = 2'd3;
   localparam logic [2:0] OP_CODE_MAX   = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_wdata = '0;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_operation = '0;
   logic [15:0] req_request_size = '0;
   logic [15:0] req_process_id = '0;
   logic [15:0] req_release_address = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_result_address;
   logic [15:0] rsp_former_address;
   logic [15:0] rsp_result_size;
   logic [15:0] rsp_result_owner;
   logic [6:0]  rsp_segment_count;
   logic        rsp_last_result;

   variable_partition_allocator #(
      .MAX_SEGMENTS(SEG_MAX),
      .TOTAL_KB(MEM_KB)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_request_size(req_request_size),
      .req_process_id(req_process_id),
      .req_release_address(req_release_address),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_result_address(rsp_result_address),
      .rsp_former_address(rsp_former_address),
      .rsp_result_size(rsp_result_size),
      .rsp_result_owner(rsp_result_owner),
      .rsp_segment_count(rsp_segment_count),
      .rsp_last_result(rsp_last_result)
   );

   always #1 clock = ~clock;

   // one response as it appears on the rsp_ ports
   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] address;
      logic [15:0] former;
      logic [15:0] size;
      logic [15:0] owner;
      logic [6:0]  count;
      logic        last;
   } alloc_rsp_type;

   // predictor copy of one table row
   typedef struct {
      int unsigned base;
      int unsigned size;
      int unsigned owner;
      bit          is_free;
      bit          swapped;
   } part_type;

   part_type      parts[SEG_MAX];
   int unsigned   part_count;
   logic [1:0]    fit_rule;
   alloc_rsp_type expected_rsps[$];
   int            mismatches = 0;
   int            cycles = 0;
   int            idle_pct = 0;

   // ---------------- segment table predictor ----------------

   function automatic void table_clear();
      foreach (parts[i]) parts[i] = '{0, 0, 0, 1'b0, 1'b0};
      parts[0] = '{0, MEM_KB, 0, 1'b1, 1'b0};
      part_count = 1;
   endfunction

   function automatic void drop_part(int unsigned idx);
      for (int unsigned j = idx; j + 1 < part_count; j++) parts[j] = parts[j + 1];
      part_count--;
   endfunction

   function automatic void add_part(int unsigned idx, part_type p);
      for (int unsigned j = part_count; j > idx; j--) parts[j] = parts[j - 1];
      parts[idx] = p;
      part_count++;
   endfunction

   function automatic bit usable(int unsigned idx);
      return parts[idx].is_free || parts[idx].swapped;
   endfunction

   // swapped and free neighbors all become one free segment
   function automatic void join_usable();
      int unsigned j = 0;
      while (j + 1 < part_count) begin
         if (usable(j) && usable(j + 1)) begin
            parts[j].size += parts[j + 1].size;
            parts[j].is_free = 1'b1;
            parts[j].swapped = 1'b0;
            parts[j].owner = 0;
            drop_part(j + 1);
         end else begin
            j++;
         end
      end
   endfunction

   function automatic void join_free();
      int unsigned j = 0;
      while (j + 1 < part_count) begin
         if (parts[j].is_free && parts[j + 1].is_free) begin
            parts[j].size += parts[j + 1].size;
            drop_part(j + 1);
         end else begin
            j++;
         end
      end
   endfunction

   function automatic int pick_hole(int unsigned want);
      int pick = -1;
      for (int unsigned j = 0; j < part_count; j++) begin
         if (!usable(j) || parts[j].size < want) continue;
         if (fit_rule == FIT_BEST) begin
            if (pick < 0 || parts[j].size < parts[pick].size) pick = int'(j);
         end else if (fit_rule == FIT_WORST) begin
            if (pick < 0 || parts[j].size > parts[pick].size) pick = int'(j);
         end else begin
            return int'(j);
         end
      end
      return pick;
   endfunction

   function automatic bit release_part(int unsigned addr, output int unsigned sz,
                                       output int unsigned ow);
      sz = 0;
      ow = 0;
      for (int unsigned j = 0; j < part_count; j++) begin
         if (parts[j].base == addr && !parts[j].is_free) begin
            sz = parts[j].size;
            ow = parts[j].owner;
            parts[j].is_free = 1'b1;
            parts[j].swapped = 1'b0;
            parts[j].owner = 0;
            join_free();
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void expect_rsp(logic [2:0] st, int unsigned ra, int unsigned fa,
                                      int unsigned rs, int unsigned ro, int unsigned cnt,
                                      bit last);
      alloc_rsp_type r;
      r.status  = st;
      r.address = ra[15:0];
      r.former  = fa[15:0];
      r.size    = rs[15:0];
      r.owner   = ro[15:0];
      r.count   = cnt[6:0];
      r.last    = last;
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   function automatic void predict_request(logic [2:0] op, logic [15:0] want,
                                           logic [15:0] pid, logic [15:0] addr);
      int          hole;
      int unsigned total, cnt, sz, ow, cursor, n;
      int unsigned want_kb, pid_id, addr_kb;
      int unsigned addrs[SEG_MAX];
      part_type    packed_parts[SEG_MAX];
      part_type    front;
      total = 0;
      cnt = 0;
      n = 0;
      cursor = 0;
      want_kb = 32'(want);
      pid_id = 32'(pid);
      addr_kb = 32'(addr);
      case (op)
         OP_ALLOC: begin
            if (want_kb == 0) begin
               expect_rsp(ST_ZERO, 0, 0, 0, 0, 0, 1'b1);
               return;
            end
            join_usable();
            hole = pick_hole(want_kb);
            if (hole < 0) begin
               expect_rsp(ST_NO_SPACE, 0, 0, 0, 0, 0, 1'b1);
            end else if (parts[hole].size == want_kb) begin
               parts[hole].is_free = 1'b0;
               parts[hole].swapped = 1'b0;
               parts[hole].owner = pid_id;
               expect_rsp(ST_OK, parts[hole].base, 0, 0, 0, 0, 1'b1);
            end else if (part_count >= SEG_MAX) begin
               expect_rsp(ST_FULL, 0, 0, 0, 0, 0, 1'b1);
            end else begin
               // split the front off; the rest keeps its swapped flag and owner
               front = '{parts[hole].base, want_kb, pid_id, 1'b0, 1'b0};
               parts[hole].base += want_kb;
               parts[hole].size -= want_kb;
               add_part(hole, front);
               expect_rsp(ST_OK, front.base, 0, 0, 0, 0, 1'b1);
            end
         end
         OP_FREE: begin
            if (release_part(addr_kb, sz, ow)) expect_rsp(ST_OK, addr_kb, 0, sz, ow, 0, 1'b1);
            else expect_rsp(ST_NOT_FOUND, 0, 0, 0, 0, 0, 1'b1);
         end
         OP_SWAP: begin
            for (int unsigned j = 0; j < part_count; j++) begin
               if (!parts[j].is_free && parts[j].owner == pid_id && !parts[j].swapped) begin
                  parts[j].swapped = 1'b1;
                  total += parts[j].size;
                  cnt++;
               end
            end
            if (cnt == 0) expect_rsp(ST_NO_SWAP, 0, 0, 0, 0, 0, 1'b1);
            else expect_rsp(ST_OK, 0, 0, total, pid_id, cnt, 1'b1);
         end
         OP_FREE_PID: begin
            for (int unsigned j = 0; j < part_count; j++)
               if (!parts[j].is_free && parts[j].owner == pid_id) addrs[n++] = parts[j].base;
            for (int unsigned j = 0; j < n; j++) begin
               if (release_part(addrs[j], sz, ow)) begin
                  total += sz;
                  cnt++;
               end
            end
            if (cnt == 0) expect_rsp(ST_NOT_FOUND, 0, 0, 0, 0, 0, 1'b1);
            else expect_rsp(ST_OK, 0, 0, total, pid_id, cnt, 1'b1);
         end
         OP_COMPACT: begin
            for (int unsigned j = 0; j < part_count; j++)
               if (!parts[j].is_free && !parts[j].swapped) packed_parts[n++] = parts[j];
            table_clear();
            if (n == 0) begin
               expect_rsp(ST_NO_COMPACT, 0, 0, 0, 0, 0, 1'b1);
               return;
            end
            for (int unsigned j = 0; j < n; j++) begin
               expect_rsp(ST_OK, cursor, packed_parts[j].base, 0, packed_parts[j].owner,
                          0, j + 1 == n);
               packed_parts[j].base = cursor;
               cursor += packed_parts[j].size;
               parts[j] = packed_parts[j];
            end
            part_count = n;
            if (cursor < MEM_KB && part_count < SEG_MAX) begin
               parts[part_count] = '{cursor, MEM_KB - cursor, 0, 1'b1, 1'b0};
               part_count++;
            end
         end
         default: ;  // unused codes: no response
      endcase
   endfunction

   // ---------------- response checker ----------------

   always @(posedge clock) begin
      alloc_rsp_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_result_address, rsp_former_address, rsp_result_size,
                rsp_result_owner, rsp_segment_count, rsp_last_result};
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------- request driving ----------------

   // called at a rising edge; returns after the request is taken and any idle wait
   task automatic send_request(logic [2:0] op, logic [15:0] want, logic [15:0] pid,
                               logic [15:0] addr);
      req_operation       <= op;
      req_request_size    <= want;
      req_process_id      <= pid;
      req_release_address <= addr;
      start               <= 1'b1;
      do @(posedge clock); while (busy);
      predict_request(op, want, pid, addr);
      if (int'($urandom_range(99)) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // hold requests off until every predicted response has arrived
   task automatic drain_responses();
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic write_fit_rule(logic [1:0] rule);
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= rule;
      @(posedge clock);
      csr_we    <= 1'b0;
      fit_rule = rule;
   endtask

   // ---------------- tests ----------------

   // empty-table corner cases, field extremes and ignored codes
   task automatic test_corners();
      send_request(OP_ALLOC, 16'd0, 16'd1, 16'd0);
      send_request(OP_ALLOC, 16'hFFFF, 16'd1, 16'd0);
      send_request(OP_FREE, 16'd0, 16'd0, 16'hFFFF);
      send_request(OP_FREE, 16'd0, 16'd0, 16'd0);
      send_request(OP_SWAP, 16'd0, 16'hFFFF, 16'd0);
      send_request(OP_FREE_PID, 16'd0, 16'd1, 16'd0);
      send_request(OP_COMPACT, 16'd0, 16'd0, 16'd0);
      for (logic [2:0] op = OP_COMPACT + 3'd1; op != 3'd0; op++)
         send_request(op, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // exact fit of the whole memory, then give it back
      send_request(OP_ALLOC, 16'(MEM_KB), 16'hFFFF, 16'd0);
      send_request(OP_ALLOC, 16'd1, 16'd2, 16'd0);
      send_request(OP_FREE, 16'd0, 16'd0, 16'd0);
   endtask

   // swapped segments get reused and split, compact drops them
   task automatic test_swap_split();
      send_request(OP_ALLOC, 16'd100, 16'd1, 16'd0);
      send_request(OP_ALLOC, 16'd200, 16'd2, 16'd0);
      send_request(OP_ALLOC, 16'd50, 16'd1, 16'd0);
      send_request(OP_SWAP, 16'd0, 16'd2, 16'd0);
      send_request(OP_SWAP, 16'd0, 16'd2, 16'd0);
      send_request(OP_ALLOC, 16'd30, 16'd3, 16'd0);
      send_request(OP_FREE, 16'd0, 16'd0, 16'd130);
      send_request(OP_SWAP, 16'd0, 16'd1, 16'd0);
      send_request(OP_COMPACT, 16'd0, 16'd0, 16'd0);
      send_request(OP_FREE_PID, 16'd0, 16'd3, 16'd0);
      send_request(OP_COMPACT, 16'd0, 16'd0, 16'd0);
   endtask

   // fill the table with one-KB pieces until a split no longer fits
   task automatic test_table_full();
      for (int k = 0; k < SEG_MAX + 2; k++) send_request(OP_ALLOC, 16'd1, 16'd9, 16'd0);
      send_request(OP_FREE, 16'd0, 16'd0, 16'd3);
      send_request(OP_ALLOC, 16'd1, 16'd8, 16'd0);
      send_request(OP_COMPACT, 16'd0, 16'd0, 16'd0);
      send_request(OP_FREE_PID, 16'd0, 16'd9, 16'd0);
      send_request(OP_FREE_PID, 16'd0, 16'd8, 16'd0);
   endtask

   // mostly well-formed traffic over a few owners, with some noise
   task automatic test_random_traffic(int items);
      int          pick, roll;
      logic [2:0]  op;
      logic [15:0] want, pid, addr;
      for (int k = 0; k < items; k++) begin
         roll = int'($urandom_range(99));
         pick = int'($urandom_range(part_count - 1));
         want = 16'($urandom_range(1, 64));
         pid  = 16'($urandom_range(0, 7));
         addr = 16'(parts[pick].base);
         if (roll < 42)      op = OP_ALLOC;
         else if (roll < 68) op = OP_FREE;
         else if (roll < 79) op = OP_SWAP;
         else if (roll < 89) op = OP_FREE_PID;
         else if (roll < 97) op = OP_COMPACT;
         else                op = 3'($urandom_range(OP_COMPACT + 1, OP_CODE_MAX));
         case ($urandom_range(19))
            0: want = 16'($urandom);
            1: want = 16'd0;
            2, 3: want = 16'(parts[pick].size);
            4, 5: want = 16'($urandom_range(1, 400));
            default: ;
         endcase
         if ($urandom_range(15) == 0) pid = 16'($urandom);
         if ($urandom_range(15) == 0) addr = 16'($urandom);
         send_request(op, want, pid, addr);
      end
   endtask

   initial begin
      table_clear();
      fit_rule = FIT_FIRST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      idle_pct = 0;
      test_corners();
      test_swap_split();
      test_table_full();

      write_fit_rule(FIT_BEST);
      test_swap_split();
      test_random_traffic(40);

      idle_pct = 83;
      write_fit_rule(FIT_WORST);
      test_swap_split();
      test_random_traffic(40);

      idle_pct = 0;
      write_fit_rule(FIT_FIRST_ALT);
      test_random_traffic(40);

      idle_pct = 36;
      write_fit_rule(FIT_FIRST);
      test_random_traffic(25);
      drain_responses();
      test_random_traffic(20);

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
